// ===== design/ctd_pkg.sv =====
// ctd_pkg: shared types, constants and helper functions of the cache tag directory
// used by ctd_ram's users and the top level; depends on nothing
`default_nettype none

package ctd_pkg;

  // directory geometry
  localparam int LINES      = 1024;
  localparam int LINE_W     = $clog2(LINES);
  localparam int PLRU_DEPTH = LINES / 4;
  localparam int PLRU_AW    = LINE_W - 2;
  localparam int PLRU_W     = 7;
  localparam int TAG_W      = 62;
  localparam int VT_W       = TAG_W + 1;
  localparam int ADDR_W     = 64;
  localparam int LIDX_W     = 10;
  localparam int CFG_W      = 3;
  localparam int LFSR_W     = 16;

  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_ASSOC  = 2'd0,
    CFG_REPL   = 2'd1,
    CFG_WALLOC = 2'd2,
    CFG_OFFB   = 2'd3
  } cfg_idx_t;

  // associativity codes
  localparam logic [1:0] ASSOC_DM = 2'd0;
  localparam logic [1:0] ASSOC_4  = 2'd1;
  localparam logic [1:0] ASSOC_8  = 2'd2;
  localparam logic [1:0] ASSOC_FA = 2'd3;

  // replacement codes
  localparam logic [1:0] REPL_LRU  = 2'd0;
  localparam logic [1:0] REPL_PLRU = 2'd1;
  localparam logic [1:0] REPL_RAND = 2'd2;

  // reset values of the configuration registers
  localparam logic [1:0] ASSOC_RST  = ASSOC_4;
  localparam logic [1:0] REPL_RST   = REPL_LRU;
  localparam logic       WALLOC_RST = 1'b1;
  localparam logic [2:0] OFFB_RST   = 3'd3;
  localparam logic [2:0] OFFB_MIN   = 3'd2;

  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] addr;
  } in_req_t;

  typedef struct packed {
    logic              hit;
    logic [LIDX_W-1:0] line_index;
    logic              filled;
    logic              victim_valid;
  } out_res_t;

  // ways minus one for an associativity code
  function automatic logic [LINE_W-1:0] way_mask(input logic [1:0] assoc);
    logic [LINE_W-1:0] m;
    m = '0;
    unique case (assoc)
      ASSOC_DM: m = '0;
      ASSOC_4:  m = LINE_W'(3);
      ASSOC_8:  m = LINE_W'(7);
      ASSOC_FA: m = '1;
    endcase
    return m;
  endfunction

  // tree plru: steer every node on the path away from the touched way
  function automatic logic [PLRU_W-1:0] plru_touch(input logic [PLRU_W-1:0] bits,
                                                   input logic [2:0] way,
                                                   input logic lv3);
    logic [PLRU_W-1:0] b;
    logic [3:0]        node;
    logic              d;
    b    = bits;
    node = '0;
    for (int lv = 2; lv >= 0; lv--) begin
      if (lv3 || lv < 2) begin
        d = way[lv];
        b[node[2:0]] = ~d;
        node = {node[2:0], 1'b0} + 4'd1 + {3'b000, d};
      end
    end
    return b;
  endfunction

  // tree plru: follow the node bits down to the victim way
  function automatic logic [2:0] plru_victim(input logic [PLRU_W-1:0] bits,
                                             input logic lv3);
    logic [2:0] way;
    logic [3:0] node;
    logic       d;
    way  = '0;
    node = '0;
    for (int lv = 0; lv < 3; lv++) begin
      if (lv3 || lv < 2) begin
        d    = bits[node[2:0]];
        way  = {way[1:0], d};
        node = {node[2:0], 1'b0} + 4'd1 + {3'b000, d};
      end
    end
    return way;
  endfunction

endpackage

`default_nettype wire

// ===== design/ctd_ram.sv =====
// ctd_ram: simple dual-port synchronous ram, one write and one registered read port
// generic storage for the directory; depends on nothing
`default_nettype none

module ctd_ram #(
  parameter int DW    = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/cache_tag_directory_replacement.sv =====
// cache_tag_directory_replacement: tag directory with lru, tree plru or lfsr replacement
// depends on ctd_pkg and ctd_ram (tag/valid, lru stack and plru stores)
//
//   channel  ports                         handshake
//   request  start, busy, in_req           taken when start && !busy
//   result   out_valid, out_res            one-cycle strobe, no back-pressure
//   config   cfg_we, cfg_idx, cfg_data     written when cfg_we, any time
//
// after reset a clearing pass sweeps the stores, busy stays high.
// a request walks the ways of its set one per cycle through the tag ram, stopping
// at the first hit, or after the last way on a miss.
// lru updates then walk the stack ram one entry per cycle.
// a final state delivers the result and writes the tag on a fill, then busy drops.
// the fully associative walk covers all LINES ways of the directory.
`default_nettype none

module cache_tag_directory_replacement (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire ctd_pkg::in_req_t           in_req,
  output logic                            out_valid,
  output ctd_pkg::out_res_t               out_res,
  input  wire logic                       cfg_we,
  input  wire logic [1:0]                 cfg_idx,
  input  wire logic [ctd_pkg::CFG_W-1:0]  cfg_data
);

  typedef enum logic [4:0] {
    ST_CLR  = 5'b00001,
    ST_IDLE = 5'b00010,
    ST_LOOK = 5'b00100,
    ST_WALK = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [ctd_pkg::LINE_W-1:0] clr_idx_r, clr_idx_nxt;
  logic [1:0]                 assoc_r, repl_r;
  logic                       walloc_r;
  logic [2:0]                 offb_r;
  logic [ctd_pkg::LFSR_W-1:0] lfsr_r, lfsr_nxt, lfsr_step;

  // latched request
  logic                       op_r, op_nxt;
  logic [ctd_pkg::TAG_W-1:0]  tag_r, tag_nxt;
  logic [ctd_pkg::LINE_W-1:0] set_r, set_nxt, base_r, base_nxt;

  // way walk counters
  logic [ctd_pkg::LINE_W-1:0] k_r, k_nxt, cw_r, cw_nxt;
  logic                       kdone_r, kdone_nxt, cv_r, cv_nxt;
  logic                       inv_found_r, inv_found_nxt;
  logic [ctd_pkg::LINE_W-1:0] inv_w_r, inv_w_nxt;

  // result and update bookkeeping
  logic                       hit_r, hit_nxt, filled_r, filled_nxt, vict_r, vict_nxt;
  logic [ctd_pkg::LINE_W-1:0] line_r, line_nxt, way_r, way_nxt;
  logic                       match_en_r, match_en_nxt;

  // ram ports
  logic                        tag_we;
  logic [ctd_pkg::LINE_W-1:0]  tag_waddr, tag_raddr;
  logic [ctd_pkg::VT_W-1:0]    tag_wdata, tag_rdata;
  logic                        lru_we;
  logic [ctd_pkg::LINE_W-1:0]  lru_waddr, lru_raddr, lru_wdata, lru_rdata;
  logic                        plru_we;
  logic [ctd_pkg::PLRU_AW-1:0] plru_waddr, plru_raddr;
  logic [ctd_pkg::PLRU_W-1:0]  plru_wdata, plru_rdata;

  // decode and policy
  logic [2:0]                 off_eff;
  logic [ctd_pkg::ADDR_W-1:0] sa;
  logic [4:0]                 dec_ib;
  logic [ctd_pkg::LINE_W-1:0] dec_set, dec_base;
  logic [ctd_pkg::LINE_W-1:0] wmask;
  logic                       pol_plru, pol_rand, pol_lru, lv3;
  logic                       tv, hit_now, any_inv;
  logic [ctd_pkg::LINE_W-1:0] first_inv, miss_w;
  logic                       walk_stop;

  ctd_ram #(.DW(ctd_pkg::VT_W), .DEPTH(ctd_pkg::LINES)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .raddr (tag_raddr),
    .rdata (tag_rdata)
  );

  ctd_ram #(.DW(ctd_pkg::LINE_W), .DEPTH(ctd_pkg::LINES)) u_lru_ram (
    .clk   (clk),
    .we    (lru_we),
    .waddr (lru_waddr),
    .wdata (lru_wdata),
    .raddr (lru_raddr),
    .rdata (lru_rdata)
  );

  ctd_ram #(.DW(ctd_pkg::PLRU_W), .DEPTH(ctd_pkg::PLRU_DEPTH)) u_plru_ram (
    .clk   (clk),
    .we    (plru_we),
    .waddr (plru_waddr),
    .wdata (plru_wdata),
    .raddr (plru_raddr),
    .rdata (plru_rdata)
  );

  // address split of the incoming request
  always_comb begin
    off_eff = (offb_r < ctd_pkg::OFFB_MIN) ? ctd_pkg::OFFB_MIN : offb_r;
    sa      = in_req.addr >> off_eff;
    dec_set  = '0;
    dec_base = '0;
    dec_ib   = '0;
    unique case (assoc_r)
      ctd_pkg::ASSOC_DM: begin
        dec_set  = sa[ctd_pkg::LINE_W-1:0];
        dec_base = sa[ctd_pkg::LINE_W-1:0];
        dec_ib   = 5'(ctd_pkg::LINE_W);
      end
      ctd_pkg::ASSOC_4: begin
        dec_set  = {2'b00, sa[ctd_pkg::LINE_W-3:0]};
        dec_base = {sa[ctd_pkg::LINE_W-3:0], 2'b00};
        dec_ib   = 5'(ctd_pkg::LINE_W - 2);
      end
      ctd_pkg::ASSOC_8: begin
        dec_set  = {3'b000, sa[ctd_pkg::LINE_W-4:0]};
        dec_base = {sa[ctd_pkg::LINE_W-4:0], 3'b000};
        dec_ib   = 5'(ctd_pkg::LINE_W - 3);
      end
      ctd_pkg::ASSOC_FA: begin
        dec_set  = '0;
        dec_base = '0;
        dec_ib   = '0;
      end
    endcase
  end

  // policy selection
  assign wmask    = ctd_pkg::way_mask(assoc_r);
  assign lv3      = (assoc_r == ctd_pkg::ASSOC_8);
  assign pol_plru = (repl_r == ctd_pkg::REPL_PLRU) &&
                    (assoc_r == ctd_pkg::ASSOC_4 || assoc_r == ctd_pkg::ASSOC_8);
  assign pol_rand = (repl_r == ctd_pkg::REPL_RAND);
  assign pol_lru  = !pol_plru && !pol_rand;

  assign lfsr_step = {lfsr_r[0] ^ lfsr_r[2] ^ lfsr_r[3] ^ lfsr_r[5], lfsr_r[15:1]};

  // compare of the way read last cycle
  assign tv        = tag_rdata[ctd_pkg::VT_W-1];
  assign hit_now   = cv_r && tv && (tag_rdata[ctd_pkg::TAG_W-1:0] == tag_r);
  assign any_inv   = inv_found_r || !tv;
  assign first_inv = inv_found_r ? inv_w_r : cw_r;

  // fill way on a miss
  always_comb begin
    if (any_inv) begin
      miss_w = first_inv;
    end else if (pol_plru) begin
      miss_w = ctd_pkg::LINE_W'(ctd_pkg::plru_victim(plru_rdata, lv3));
    end else if (pol_rand) begin
      miss_w = lfsr_step[ctd_pkg::LINE_W-1:0] & wmask;
    end else begin
      miss_w = lru_rdata & wmask;
    end
  end

  assign walk_stop = (match_en_r && (lru_rdata == way_r)) || (cw_r == wmask);

  // read addresses: ways of the set, the stack bottom, the set's plru bits
  assign tag_raddr  = base_r | (k_r & wmask);
  assign lru_raddr  = (state_r == ST_WALK) ? (base_r | (k_r & wmask)) : (base_r | wmask);
  assign plru_raddr = set_r[ctd_pkg::PLRU_AW-1:0];

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    lfsr_nxt      = lfsr_r;
    op_nxt        = op_r;
    tag_nxt       = tag_r;
    set_nxt       = set_r;
    base_nxt      = base_r;
    k_nxt         = k_r;
    kdone_nxt     = kdone_r;
    cv_nxt        = 1'b0;
    cw_nxt        = cw_r;
    inv_found_nxt = inv_found_r;
    inv_w_nxt     = inv_w_r;
    hit_nxt       = hit_r;
    filled_nxt    = filled_r;
    vict_nxt      = vict_r;
    line_nxt      = line_r;
    way_nxt       = way_r;
    match_en_nxt  = match_en_r;
    tag_we        = 1'b0;
    tag_waddr     = line_r;
    tag_wdata     = {1'b1, tag_r};
    lru_we        = 1'b0;
    lru_waddr     = base_r;
    lru_wdata     = way_r;
    plru_we       = 1'b0;
    plru_waddr    = set_r[ctd_pkg::PLRU_AW-1:0];
    plru_wdata    = ctd_pkg::plru_touch(plru_rdata, line_nxt[2:0], lv3);

    // issue one read per cycle while walking
    if ((state_r == ST_LOOK || state_r == ST_WALK) && !kdone_r) begin
      cv_nxt = 1'b1;
      cw_nxt = k_r;
      if (k_r == wmask) begin
        kdone_nxt = 1'b1;
      end else begin
        k_nxt = k_r + 1'b1;
      end
    end

    unique case (state_r)
      ST_CLR: begin
        tag_we     = 1'b1;
        tag_waddr  = clr_idx_r;
        tag_wdata  = '0;
        lru_we     = 1'b1;
        lru_waddr  = clr_idx_r;
        lru_wdata  = '0;
        plru_we    = 1'b1;
        plru_waddr = clr_idx_r[ctd_pkg::PLRU_AW-1:0];
        plru_wdata = '0;
        if (clr_idx_r == '1) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (start) begin
          op_nxt        = in_req.op;
          tag_nxt       = ctd_pkg::TAG_W'(sa >> dec_ib);
          set_nxt       = dec_set;
          base_nxt      = dec_base;
          k_nxt         = '0;
          kdone_nxt     = 1'b0;
          inv_found_nxt = 1'b0;
          state_nxt     = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (cv_r) begin
          if (!tv && !inv_found_r) begin
            inv_found_nxt = 1'b1;
            inv_w_nxt     = cw_r;
          end
          if (hit_now) begin
            // hit: refresh replacement state
            hit_nxt      = 1'b1;
            filled_nxt   = 1'b0;
            vict_nxt     = 1'b0;
            line_nxt     = base_r | cw_r;
            way_nxt      = cw_r;
            match_en_nxt = 1'b1;
            state_nxt    = ST_FIN;
            if (assoc_r != ctd_pkg::ASSOC_DM) begin
              if (pol_plru) begin
                plru_we    = 1'b1;
                plru_wdata = ctd_pkg::plru_touch(plru_rdata, cw_r[2:0], lv3);
              end else if (pol_lru) begin
                // drop the tag read in flight so the stack walk starts clean
                cv_nxt    = 1'b0;
                k_nxt     = '0;
                kdone_nxt = 1'b0;
                state_nxt = ST_WALK;
              end
            end
          end else if (cw_r == wmask) begin
            hit_nxt   = 1'b0;
            state_nxt = ST_FIN;
            if (!op_r || walloc_r) begin
              // miss with allocation
              filled_nxt = 1'b1;
              if (assoc_r == ctd_pkg::ASSOC_DM) begin
                vict_nxt = tv;
                line_nxt = base_r;
              end else begin
                vict_nxt     = !any_inv;
                line_nxt     = base_r | miss_w;
                way_nxt      = miss_w;
                match_en_nxt = 1'b0;
                if (!any_inv && pol_rand) begin
                  lfsr_nxt = lfsr_step;
                end
                if (pol_plru) begin
                  plru_we    = 1'b1;
                  plru_wdata = ctd_pkg::plru_touch(plru_rdata, miss_w[2:0], lv3);
                end else if (pol_lru) begin
                  k_nxt     = '0;
                  kdone_nxt = 1'b0;
                  state_nxt = ST_WALK;
                end
              end
            end else begin
              filled_nxt = 1'b0;
              vict_nxt   = 1'b0;
              line_nxt   = '0;
            end
          end
        end
      end
      ST_WALK: begin
        // shift the stack down one entry per cycle, way on top at the end
        if (cv_r) begin
          lru_we = 1'b1;
          if (walk_stop) begin
            lru_waddr = base_r;
            lru_wdata = way_r;
            state_nxt = ST_FIN;
          end else begin
            lru_waddr = base_r | (cw_r + 1'b1);
            lru_wdata = lru_rdata;
          end
        end
      end
      ST_FIN: begin
        tag_we    = filled_r;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLR;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_idx_r   <= '0;
      lfsr_r      <= ctd_pkg::LFSR_SEED;
      k_r         <= '0;
      kdone_r     <= 1'b1;
      cv_r        <= 1'b0;
      inv_found_r <= 1'b0;
      assoc_r     <= ctd_pkg::ASSOC_RST;
      repl_r      <= ctd_pkg::REPL_RST;
      walloc_r    <= ctd_pkg::WALLOC_RST;
      offb_r      <= ctd_pkg::OFFB_RST;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      lfsr_r      <= lfsr_nxt;
      k_r         <= k_nxt;
      kdone_r     <= kdone_nxt;
      cv_r        <= cv_nxt;
      inv_found_r <= inv_found_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          ctd_pkg::CFG_ASSOC:  assoc_r  <= cfg_data[1:0];
          ctd_pkg::CFG_REPL:   repl_r   <= cfg_data[1:0];
          ctd_pkg::CFG_WALLOC: walloc_r <= cfg_data[0];
          ctd_pkg::CFG_OFFB:   offb_r   <= cfg_data;
          default:             offb_r   <= offb_r;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    tag_r      <= tag_nxt;
    set_r      <= set_nxt;
    base_r     <= base_nxt;
    cw_r       <= cw_nxt;
    inv_w_r    <= inv_w_nxt;
    hit_r      <= hit_nxt;
    filled_r   <= filled_nxt;
    vict_r     <= vict_nxt;
    line_r     <= line_nxt;
    way_r      <= way_nxt;
    match_en_r <= match_en_nxt;
  end

  // ports
  assign busy                 = (state_r != ST_IDLE);
  assign out_valid            = (state_r == ST_FIN);
  assign out_res.hit          = hit_r;
  assign out_res.line_index   = ctd_pkg::LIDX_W'({{ctd_pkg::LIDX_W{1'b0}}, line_r});
  assign out_res.filled       = filled_r;
  assign out_res.victim_valid = vict_r;

`ifndef SYNTHESIS
  a_one_cycle_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_hit_no_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_res.hit && out_res.filled)) else $error("hit and fill together");

  a_victim_needs_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.victim_valid |-> out_res.filled)
    else $error("victim reported without fill");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("request accepted but not busy");

  a_walk_single_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK && cv_r |-> lru_we) else $error("stack walk skipped a write");
`endif

endmodule

`default_nettype wire

// ===== bench/ctd_checker.sv =====
// ctd_checker: watches the request and result channels of the tag directory,
// predicts each result and compares it; depends on ctd_pkg
`timescale 1ns / 100ps

module ctd_checker (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    busy,
  input  ctd_pkg::in_req_t        in_req,
  input  logic                    out_valid,
  input  ctd_pkg::out_res_t       out_res,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_idx,
  input  logic [ctd_pkg::CFG_W-1:0] cfg_data,
  output int                      fail_count,
  output int                      pending,
  output int                      req_count,
  output int                      hits_seen,
  output int                      victim_count
);

  localparam int N = ctd_pkg::LINES;

  // predicted directory state
  logic [ctd_pkg::TAG_W-1:0] tags [N];
  logic             valid [N];
  logic [15:0]      stack [N];
  logic [6:0]       tree [N/4];
  logic [15:0]      lfsr;
  logic [1:0]       assoc;
  logic [1:0]       repl;
  logic             walloc;
  logic [2:0]       offb;

  ctd_pkg::out_res_t expected_q [$];

  // mismatch report
  task automatic report_mismatch(input string what, input ctd_pkg::out_res_t got,
                                 input ctd_pkg::out_res_t exp);
    $display({"%0t mismatch %s: got hit=%0b line=%0d fill=%0b vict=%0b,",
              " exp hit=%0b line=%0d fill=%0b vict=%0b"},
             $time, what, got.hit, got.line_index, got.filled, got.victim_valid,
             exp.hit, exp.line_index, exp.filled, exp.victim_valid);
    fail_count++;
  endtask

  // move entries base..base+pos-1 down one and put way on top
  task automatic stack_push(input int base, input int pos, input int way);
    for (int i = pos; i > 0; i--) stack[base+i] = stack[base+i-1];
    stack[base] = 16'(way);
  endtask

  task automatic tree_touch(input int set, input int way, input int levels);
    int node;
    int d;
    logic [6:0] b;
    node = 0;
    b = tree[set];
    for (int lv = levels; lv > 0; lv--) begin
      d = (way >> (lv - 1)) & 1;
      b[node] = (d == 0);
      node = 2 * node + 1 + d;
    end
    tree[set] = b;
  endtask

  function automatic int tree_victim(input int set, input int levels);
    int node;
    int way;
    int d;
    node = 0;
    way = 0;
    for (int lv = 0; lv < levels; lv++) begin
      d = tree[set][node];
      way = way * 2 + d;
      node = 2 * node + 1 + d;
    end
    return way;
  endfunction

  // lookup and replacement for one request
  task automatic predict_access(input ctd_pkg::in_req_t r, output ctd_pkg::out_res_t res);
    int off, ways, sets, ib, set, base, w, pol, levels, line;
    logic [ctd_pkg::TAG_W-1:0] tag;
    logic hit, filled, vict, found;
    off = (offb < 2) ? 2 : offb;
    ways = (assoc == ctd_pkg::ASSOC_DM) ? 1 : (assoc == ctd_pkg::ASSOC_4) ? 4 :
           (assoc == ctd_pkg::ASSOC_8) ? 8 : N;
    sets = N / ways;
    ib = $clog2(sets);
    set = int'((r.addr >> off) % sets);
    tag = ctd_pkg::TAG_W'(r.addr >> (off + ib));
    base = set * ways;
    pol = repl;
    if (pol == 3 || (pol == ctd_pkg::REPL_PLRU && ways != 4 && ways != 8))
      pol = ctd_pkg::REPL_LRU;
    levels = (ways == 8) ? 3 : 2;
    hit = 0; filled = 0; vict = 0; found = 0; line = 0;
    for (w = 0; w < ways; w++)
      if (valid[base+w] && tags[base+w] == tag) begin
        hit = 1;
        break;
      end
    if (hit) begin
      line = base + w;
      if (assoc != ctd_pkg::ASSOC_DM) begin
        if (pol == ctd_pkg::REPL_PLRU) tree_touch(set, w, levels);
        else if (pol == ctd_pkg::REPL_LRU) begin
          int i;
          for (i = 0; i < ways; i++) if (stack[base+i] == w) break;
          if (i >= ways) i = ways - 1;
          stack_push(base, i, w);
        end
      end
    end else if (r.op == 1'b0 || walloc) begin
      filled = 1;
      if (assoc == ctd_pkg::ASSOC_DM) begin
        w = 0;
        vict = valid[base];
      end else begin
        for (w = 0; w < ways; w++)
          if (!valid[base+w]) begin
            found = 1;
            break;
          end
        if (!found) begin
          vict = 1;
          if (pol == ctd_pkg::REPL_PLRU) w = tree_victim(set, levels);
          else if (pol == ctd_pkg::REPL_RAND) begin
            lfsr = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[15:1]};
            w = lfsr % ways;
          end else w = stack[base+ways-1] % ways;
        end
        if (pol == ctd_pkg::REPL_PLRU) tree_touch(set, w, levels);
        else if (pol == ctd_pkg::REPL_LRU) stack_push(base, ways - 1, w);
      end
      line = base + w;
      tags[line] = tag;
      valid[line] = 1;
    end
    res.hit = hit;
    res.line_index = ctd_pkg::LIDX_W'(line);
    res.filled = filled;
    res.victim_valid = vict;
  endtask

  // watch config, requests and results
  always @(posedge clk) begin
    ctd_pkg::out_res_t exp;
    if (!rst_n) begin
      for (int i = 0; i < N; i++) begin
        valid[i] = 0;
        stack[i] = '0;
        tags[i] = '0;
      end
      for (int i = 0; i < N / 4; i++) tree[i] = '0;
      lfsr = ctd_pkg::LFSR_SEED;
      assoc = ctd_pkg::ASSOC_RST;
      repl = ctd_pkg::REPL_RST;
      walloc = ctd_pkg::WALLOC_RST;
      offb = ctd_pkg::OFFB_RST;
      expected_q.delete();
      fail_count = 0;
      req_count = 0;
      hits_seen = 0;
      victim_count = 0;
    end else begin
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          exp = '0;
          report_mismatch("unexpected result", out_res, exp);
        end else begin
          exp = expected_q.pop_front();
          if (out_res.hit != exp.hit) report_mismatch("hit", out_res, exp);
          if (out_res.line_index != exp.line_index) report_mismatch("line_index", out_res, exp);
          if (out_res.filled != exp.filled) report_mismatch("filled", out_res, exp);
          if (out_res.victim_valid != exp.victim_valid)
            report_mismatch("victim_valid", out_res, exp);
          hits_seen += exp.hit;
          victim_count += exp.victim_valid;
        end
      end
      if (start && !busy) begin
        predict_access(in_req, exp);
        expected_q.push_back(exp);
        req_count++;
      end
      if (cfg_we) begin
        case (ctd_pkg::cfg_idx_t'(cfg_idx))
          ctd_pkg::CFG_ASSOC:  assoc = cfg_data[1:0];
          ctd_pkg::CFG_REPL:   repl = cfg_data[1:0];
          ctd_pkg::CFG_WALLOC: walloc = cfg_data[0];
          ctd_pkg::CFG_OFFB:   offb = cfg_data;
        endcase
      end
    end
    pending = expected_q.size();
  end
endmodule

// ===== bench/cache_tag_directory_replacement_tb.sv =====
// cache_tag_directory_replacement_tb: drives accesses through several directory
// configurations; depends on ctd_pkg, the block and ctd_checker
`timescale 1ns / 100ps

module cache_tag_directory_replacement_tb;

  localparam int STALL_LIMIT = 20000;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  ctd_pkg::in_req_t in_req = '0;
  logic out_valid;
  ctd_pkg::out_res_t out_res;
  logic cfg_we = 0;
  logic [1:0] cfg_idx = '0;
  logic [ctd_pkg::CFG_W-1:0] cfg_data = '0;
  int fail_count, pending, req_count, hits_seen, victim_count;
  int idle_cycles = 0;

  always #2 clk = ~clk;

  cache_tag_directory_replacement dut (.*);

  ctd_checker chk (.*);

  // watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout");
      $display("cache_tag_directory_replacement_tb NOT OK");
      $finish;
    end
  end

  // one request, held until taken
  task automatic send_req(input logic op, input logic [ctd_pkg::ADDR_W-1:0] addr);
    start <= 1;
    in_req <= '{op: op, addr: addr};
    do @(posedge clk); while (busy);
    start <= 0;
    @(posedge clk);
  endtask

  // wait until every expected result has come and the block is idle
  task automatic drain();
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_cfg(input ctd_pkg::cfg_idx_t idx, input int val);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_data <= ctd_pkg::CFG_W'(val);
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // random address: mode 0 is fully random, other modes use few tags per set so hits and evictions both occur
  function automatic logic [ctd_pkg::ADDR_W-1:0] pick_addr(input int mode);
    logic [ctd_pkg::ADDR_W-1:0] a;
    if (mode == 0) a = {$urandom, $urandom};
    else begin
      a = ctd_pkg::ADDR_W'($urandom_range(0, 63)) << 3;
      a = a ^ (ctd_pkg::ADDR_W'($urandom_range(0, 11)) << 13);
      if ($urandom_range(0, 7) == 0) a[63:58] = 6'($urandom);
      a[2:0] = 3'($urandom);
    end
    return a;
  endfunction

  task automatic run_burst(input int count);
    int gap;
    for (int i = 0; i < count; i++) begin
      send_req(1'($urandom), pick_addr($urandom_range(0, 9) == 0));
      if ($urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 6);
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    int assoc_v, repl_v, offb_v;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: field extremes and special cases in the reset configuration, then with write allocation off
    send_req(0, '0);
    send_req(0, '0);
    send_req(1, '1);
    send_req(0, '1);
    send_req(1, 64'h5555_5555_5555_5555);
    send_req(0, 64'hAAAA_AAAA_AAAA_AAAA);
    for (int k = 0; k < 6; k++) send_req(0, ctd_pkg::ADDR_W'(k) << 11);
    send_req(0, 64'h0);
    drain();
    write_cfg(ctd_pkg::CFG_WALLOC, 0);
    send_req(1, 64'h1234_0000);
    send_req(0, 64'h1234_0000);
    send_req(1, 64'h1234_0000);
    drain();

    // random phases through configurations, extremes included
    for (int ph = 0; ph < 20; ph++) begin
      assoc_v = (ph < 4) ? ph : $urandom_range(0, 3);
      repl_v = (ph < 4) ? 3 - ph : $urandom_range(0, 3);
      offb_v = (ph == 1) ? 0 : (ph == 2) ? 7 : (ph == 3) ? 1 : $urandom_range(0, 7);
      write_cfg(ctd_pkg::CFG_ASSOC, assoc_v);
      write_cfg(ctd_pkg::CFG_REPL, repl_v);
      write_cfg(ctd_pkg::CFG_WALLOC, $urandom_range(0, 1));
      write_cfg(ctd_pkg::CFG_OFFB, offb_v);
      run_burst(assoc_v == 3 ? 20 : 55);
      drain();
    end

    $display("requests %0d, hits %0d, victim fills %0d over 20 configurations",
             req_count, hits_seen, victim_count);
    if (fail_count == 0) $display("cache_tag_directory_replacement_tb OK");
    else $display("cache_tag_directory_replacement_tb NOT OK");
    $finish;
  end
endmodule
